### sv/integer_list_sorter_defines.svh
// assertion macros for the integer list sorter, used by ils_ctrl
// expects clk and rst_n in the scope of each use
`ifndef INTEGER_LIST_SORTER_DEFINES_SVH
`define INTEGER_LIST_SORTER_DEFINES_SVH

// implication checked on the following clock edge
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// property that holds at every clock edge
`define ILS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

### sv/ils_pkg.sv
// shared types and constants for the integer list sorter
// no dependencies
package ils_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;

    typedef struct packed {
        logic insert;
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

### sv/ils_cell.sv
// one cell of the insertion chain: holds one element and its valid bit
// depends on ils_pkg
module ils_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ils_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [ils_pkg::DATA_W-1:0]   new_value,
    input  logic signed [ils_pkg::DATA_W-1:0]   lo_value,
    input  logic                                lo_valid,
    input  logic                                lo_gt,
    input  logic signed [ils_pkg::DATA_W-1:0]   hi_value,
    input  logic                                hi_valid,
    output logic signed [ils_pkg::DATA_W-1:0]   value,
    output logic                                valid,
    output logic                                gt
);
    import ils_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     valid_reg;
    logic                     valid_next;

    // new element belongs at or below this cell
    assign gt = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (lo_gt)
            begin
                value_next = lo_value;
                valid_next = lo_valid;
            end
            else if (gt)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift_up)
        begin
            value_next = lo_value;
            valid_next = lo_valid;
        end
        else if (ctrl.shift_down)
        begin
            value_next = hi_value;
            valid_next = hi_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

### sv/ils_ctrl.sv
// load and drain sequencer, element count, overflow and direction register
// depends on ils_pkg and integer_list_sorter_defines.svh
module ils_ctrl #(
    parameter int MAX_ITEMS = ils_pkg::MAX_ITEMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                last_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                last_out,
    output logic                overflow,
    input  logic                bottom_valid,
    input  logic                top_valid,
    output logic                take_bottom,
    output ils_pkg::cell_ctrl_t cell_ctrl
);
    import ils_pkg::*;
    `include "integer_list_sorter_defines.svh"

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             asc_reg;
    logic             asc_next;
    logic             dir_asc_reg;
    logic             dir_asc_next;

    logic             in_acc;
    logic             out_acc;
    logic             full;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(MAX_ITEMS));

    assign take_bottom = dir_asc_reg;
    assign out_valid   = (state_reg == ST_DRAIN) && (dir_asc_reg ? bottom_valid : top_valid);
    assign out_acc     = out_valid && out_ready;
    assign last_out    = (count_reg == CNT_W'(1));
    assign overflow    = ovf_reg;

    always_comb
    begin
        cell_ctrl.insert     = in_acc && !full;
        cell_ctrl.shift_down = (state_reg == ST_DRAIN) && dir_asc_reg && out_acc;
        cell_ctrl.shift_up   = (state_reg == ST_DRAIN) && !dir_asc_reg
                               && (out_acc || !top_valid);
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        dir_asc_next = dir_asc_reg;
        asc_next     = asc_reg;
        if (cfg_valid && cfg_ready)
        begin
            asc_next = cfg_data;
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_in)
                    begin
                        state_next   = ST_DRAIN;
                        dir_asc_next = asc_reg;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (last_out)
                    begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            asc_reg     <= 1'b1;
            dir_asc_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            asc_reg     <= asc_next;
            dir_asc_reg <= dir_asc_next;
        end
    end

    `ILS_ASSERT_NEXT(a_close_starts_drain, in_acc && last_in, state_reg == ST_DRAIN, "closing transaction did not start drain")
    `ILS_ASSERT_NEXT(a_final_ends_drain, out_acc && last_out, (state_reg == ST_LOAD) && (count_reg == '0), "final transaction did not return to load")
    `ILS_ASSERT_ALWAYS(a_drain_nonempty, (state_reg != ST_DRAIN) || (count_reg != '0), "drain with no elements left")
    `ILS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_ITEMS), "element count beyond capacity")

endmodule

### sv/integer_list_sorter.sv
// Integer list sorter: signed 32-bit elements enter on the input channel (value,
// last_in), one transaction per element; the transaction with last_in high closes
// the list. The sorted list then leaves on the output channel (sorted_value,
// last_out, overflow), last_out marking its final element and overflow set on
// every element of a list longer than MAX_ITEMS, whose extra elements are dropped.
// The cfg channel writes the ascending bit (1 smallest first), sampled when the
// list closes; its ready is always high.
// Loading takes one element per cycle: a chain of MAX_ITEMS cells keeps the list
// sorted as it arrives, each new element compared in every cell at once.
// Ascending lists start draining the cycle after the closing transaction; descending
// lists first shift up the chain until its largest element reaches the top cell.
// Either way results leave one per cycle while out_ready is high, straight from
// the chain's end cell. The input is not ready while a list drains, so a new list
// cannot start loading until the previous one has fully left the block.
// A stalled receiver freezes the chain with the result held on the ports.
// Reset empties the chain, clears the count and overflow, and sets ascending.
module integer_list_sorter #(
    parameter int MAX_ITEMS = ils_pkg::MAX_ITEMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ils_pkg::DATA_W-1:0] value,
    input  logic                              last_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ils_pkg::DATA_W-1:0] sorted_value,
    output logic                              last_out,
    output logic                              overflow
);
    import ils_pkg::*;

    cell_ctrl_t               cell_ctrl;
    logic                     take_bottom;
    logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
    logic                     cell_valid [MAX_ITEMS];
    logic                     cell_gt    [MAX_ITEMS];

    ils_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .last_out     (last_out),
        .overflow     (overflow),
        .bottom_valid (cell_valid[0]),
        .top_valid    (cell_valid[MAX_ITEMS-1]),
        .take_bottom  (take_bottom),
        .cell_ctrl    (cell_ctrl)
    );

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] lo_value;
        logic                     lo_valid;
        logic                     lo_gt;
        logic signed [DATA_W-1:0] hi_value;
        logic                     hi_valid;

        if (i == 0)
        begin : g_first
            assign lo_value = value;
            assign lo_valid = 1'b0;
            assign lo_gt    = 1'b0;
        end
        else
        begin : g_mid_lo
            assign lo_value = cell_value[i-1];
            assign lo_valid = cell_valid[i-1];
            assign lo_gt    = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_last
            assign hi_value = value;
            assign hi_valid = 1'b0;
        end
        else
        begin : g_mid_hi
            assign hi_value = cell_value[i+1];
            assign hi_valid = cell_valid[i+1];
        end

        ils_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .new_value (value),
            .lo_value  (lo_value),
            .lo_valid  (lo_valid),
            .lo_gt     (lo_gt),
            .hi_value  (hi_value),
            .hi_valid  (hi_valid),
            .value     (cell_value[i]),
            .valid     (cell_valid[i]),
            .gt        (cell_gt[i])
        );
    end

    assign sorted_value = take_bottom ? cell_value[0] : cell_value[MAX_ITEMS-1];

endmodule
